>>> src/mcnf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcnf_pkg
// Shared types and codes for the cluster note filter: request codes,
// sequencer states, row commands and the snap chain record.
// ----------------------------------------------------------------------------
package mcnf_pkg;

  localparam int PITCH_W = 7;

  localparam logic [1:0] REQ_LOCAL = 2'd0;
  localparam logic [1:0] REQ_EXT   = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ON1,
    S_ON2,
    S_ON3,
    S_PUSH,
    S_OFF1,
    S_PAIRS,
    S_REMOVE,
    S_EXT,
    S_CLR,
    S_DONE
  } state_t;

  // Command broadcast to every cell of one row
  typedef struct packed {
    logic push;
    logic remove;
    logic clear;
  } row_cmd_t;

  // Nearest-match record handed from cell to cell
  typedef struct packed {
    logic                found;
    logic [PITCH_W-1:0]  pitch;
  } snap_t;

endpackage

>>> src/mcnf_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcnf_cell
// One list slot: holds an entry and its occupied bit, matches the broadcast
// key and hands shift, first-match and nearest-note data to its neighbors.
// ----------------------------------------------------------------------------
module mcnf_cell
  import mcnf_pkg::*;
#(
  parameter int VW = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  row_cmd_t           cmd,
  input  logic [PITCH_W-1:0] key,
  input  logic [VW-1:0]      push_val,
  input  logic               left_occ,
  input  logic               hit_in,
  input  logic [VW-1:0]      fm_in,
  input  logic [VW-1:0]      right_val,
  input  logic               right_occ,
  input  snap_t              snap_in,
  output logic [VW-1:0]      val,
  output logic               occ,
  output logic               hit_out,
  output logic [VW-1:0]      fm_out,
  output snap_t              snap_out
);

  logic [PITCH_W-1:0] kv;
  logic               match;
  logic               near;
  logic               take_push;
  logic               take_right;

  // Compare the key field against the broadcast key
  assign kv    = val[VW-1 -: PITCH_W];
  assign match = occ && (kv == key);
  assign near  = occ && (({1'b0, kv} == {1'b0, key} + 8'd1) ||
                         ({1'b0, kv} == {1'b0, key} + 8'd2) ||
                         ({1'b0, key} == {1'b0, kv} + 8'd1) ||
                         ({1'b0, key} == {1'b0, kv} + 8'd2));

  // Pass the first match to the right and the last near note to the left
  assign hit_out = hit_in | match;
  assign fm_out  = (!hit_in && match) ? val : fm_in;
  always_comb begin
    snap_out = snap_in;
    if (!snap_in.found && near) begin
      snap_out.found = 1'b1;
      snap_out.pitch = kv;
    end
  end

  assign take_right = cmd.remove && hit_out;
  assign take_push  = cmd.push && !occ && left_occ;

  // Hold, clear, shift down on removal, or load on push
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (cmd.clear) begin
      occ <= 1'b0;
    end else if (take_right) begin
      occ <= right_occ;
    end else if (take_push) begin
      occ <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take_right) begin
      val <= right_val;
    end else if (take_push) begin
      val <= push_val;
    end
  end

endmodule

>>> src/mcnf_row.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcnf_row
// Ordered list built as a row of cells; reports full, key hit, the first
// matching entry and the last entry near the key.
// ----------------------------------------------------------------------------
module mcnf_row
  import mcnf_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int VW    = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  row_cmd_t           cmd,
  input  logic [PITCH_W-1:0] key,
  input  logic [VW-1:0]      push_val,
  output logic               full,
  output logic               any_hit,
  output logic [VW-1:0]      first_val,
  output snap_t              snap
);

  logic [VW-1:0] vals  [DEPTH];
  logic [DEPTH-1:0] occs;
  logic [DEPTH:0]   hits;
  logic [VW-1:0] fms   [DEPTH+1];
  snap_t         snaps [DEPTH+1];

  assign hits[0]      = 1'b0;
  assign fms[0]       = '0;
  assign snaps[DEPTH] = '0;

  // Chain the cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic          lo;
    logic [VW-1:0] rv;
    logic          ro;
    if (i == 0) begin : g_first
      assign lo = 1'b1;
    end else begin : g_mid
      assign lo = occs[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rv = '0;
      assign ro = 1'b0;
    end else begin : g_inner
      assign rv = vals[i+1];
      assign ro = occs[i+1];
    end
    mcnf_cell #(.VW(VW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .key      (key),
      .push_val (push_val),
      .left_occ (lo),
      .hit_in   (hits[i]),
      .fm_in    (fms[i]),
      .right_val(rv),
      .right_occ(ro),
      .snap_in  (snaps[i+1]),
      .val      (vals[i]),
      .occ      (occs[i]),
      .hit_out  (hits[i+1]),
      .fm_out   (fms[i+1]),
      .snap_out (snaps[i])
    );
  end

  assign full      = occs[DEPTH-1];
  assign any_hit   = hits[DEPTH];
  assign first_val = fms[DEPTH];
  assign snap      = snaps[0];

endmodule

>>> src/midi_cluster_note_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_cluster_note_filter
// Cluster note filter: snaps local note-ons onto nearby held notes, maps
// note-offs back through the pair list and tracks held notes in cell rows.
// ----------------------------------------------------------------------------
//   channel  | handshake          | payload
//   ---------+--------------------+---------------------------------------------
//   input    | in_valid, in_stall | req_type, note_pitch, note_velocity
//   output   | out_valid,out_stall| note_valid, out_pitch, out_velocity,
//            |                    | was_reassigned, store_overflow,
//            |                    | main_count, local_count
//
// One item at a time. A note-on snaps at most three times, and a mapped note-off
// removes its pairs one at a time; each snap pass and each pair removal is one
// sweep of the cell rows.
// Synchronous active-high reset empties every list at once.
// in_stall is high while an item is in flight; a stalled result holds.
// ----------------------------------------------------------------------------
module midi_cluster_note_filter
  import mcnf_pkg::*;
#(
  parameter int MAIN_DEPTH  = 256,
  parameter int LOCAL_DEPTH = 32,
  parameter int REMAP_DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [1:0]   req_type,
  input  logic [6:0]   note_pitch,
  input  logic [6:0]   note_velocity,
  output logic         out_valid,
  input  logic         out_stall,
  output logic         note_valid,
  output logic [6:0]   out_pitch,
  output logic [6:0]   out_velocity,
  output logic         was_reassigned,
  output logic         store_overflow,
  output logic [8:0]   main_count,
  output logic [5:0]   local_count
);

  localparam int MFW = $clog2(MAIN_DEPTH + 1);
  localparam int LFW = $clog2(LOCAL_DEPTH + 1);
  localparam int RFW = $clog2(REMAP_DEPTH + 1);

  state_t state, state_next;

  logic [1:0]         req;
  logic [PITCH_W-1:0] pitch;
  logic [PITCH_W-1:0] vel;
  logic [PITCH_W-1:0] key;
  logic [PITCH_W-1:0] opitch;
  logic               emit;
  logic               ovf;
  logic [MFW-1:0]     main_fill;
  logic [LFW-1:0]     local_fill;
  logic [RFW-1:0]     remap_fill;

  row_cmd_t           main_cmd, local_cmd, pair_cmd;
  logic               key_load;
  logic [PITCH_W-1:0] key_val;
  logic               set_emit;
  logic [PITCH_W-1:0] emit_pitch;
  logic               set_ovf;
  logic               accept;

  logic               main_full, local_full, pair_full;
  logic               main_hit, local_hit, pair_hit;
  logic [PITCH_W-1:0] main_first, local_first;
  logic [2*PITCH_W-1:0] pair_first;
  snap_t              main_snap, local_snap, pair_snap;
  logic [31:0]        mf32, lf32;

  // Note lists and pair list
  mcnf_row #(.DEPTH(MAIN_DEPTH), .VW(PITCH_W)) u_main (
    .clk(clk), .rst(rst), .cmd(main_cmd), .key(key), .push_val(key),
    .full(main_full), .any_hit(main_hit), .first_val(main_first), .snap(main_snap)
  );

  mcnf_row #(.DEPTH(LOCAL_DEPTH), .VW(PITCH_W)) u_local (
    .clk(clk), .rst(rst), .cmd(local_cmd), .key(key), .push_val(key),
    .full(local_full), .any_hit(local_hit), .first_val(local_first),
    .snap(local_snap)
  );

  mcnf_row #(.DEPTH(REMAP_DEPTH), .VW(2 * PITCH_W)) u_pair (
    .clk(clk), .rst(rst), .cmd(pair_cmd), .key(key), .push_val({pitch, key}),
    .full(pair_full), .any_hit(pair_hit), .first_val(pair_first), .snap(pair_snap)
  );

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          priority if (req_type == REQ_LOCAL && note_velocity != '0) state_next = S_ON1;
          else if (req_type == REQ_LOCAL) state_next = S_OFF1;
          else if (req_type == REQ_EXT)   state_next = S_EXT;
          else if (req_type == REQ_CLEAR) state_next = S_CLR;
          else                            state_next = S_DONE;
        end
      end
      S_ON1: begin
        if (main_fill != '0 && !local_hit && !local_snap.found && main_snap.found) begin
          state_next = S_ON2;
        end else begin
          state_next = S_DONE;
        end
      end
      S_ON2:    state_next = main_snap.found ? S_ON3 : S_PUSH;
      S_ON3:    state_next = main_snap.found ? S_DONE : S_PUSH;
      S_PUSH:   state_next = S_DONE;
      S_OFF1: begin
        if (remap_fill != '0 && pair_hit) state_next = S_PAIRS;
        else                               state_next = S_DONE;
      end
      S_PAIRS:  state_next = pair_hit ? S_PAIRS : S_REMOVE;
      S_REMOVE: state_next = S_DONE;
      S_EXT:    state_next = S_DONE;
      S_CLR:    state_next = S_DONE;
      S_DONE:   state_next = (!out_valid || !out_stall) ? S_IDLE : S_DONE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Row commands and result updates per state
  always_comb begin
    main_cmd   = '0;
    local_cmd  = '0;
    pair_cmd   = '0;
    key_load   = 1'b0;
    key_val    = key;
    set_emit   = 1'b0;
    emit_pitch = key;
    set_ovf    = 1'b0;
    unique case (state)
      S_ON1: begin
        priority if (main_fill == '0) begin
          main_cmd.push  = 1'b1;
          local_cmd.push = 1'b1;
          set_emit       = 1'b1;
          set_ovf        = main_full || local_full;
        end else if (local_hit) begin
          set_emit = 1'b1;
        end else if (local_snap.found) begin
          set_emit = 1'b0;
        end else if (!main_snap.found) begin
          main_cmd.push  = 1'b1;
          local_cmd.push = 1'b1;
          set_emit       = 1'b1;
          set_ovf        = main_full || local_full;
        end else begin
          key_load = 1'b1;
          key_val  = main_snap.pitch;
        end
      end
      S_ON2, S_ON3: begin
        if (main_snap.found) begin
          key_load = 1'b1;
          key_val  = main_snap.pitch;
        end
      end
      S_PUSH: begin
        main_cmd.push  = 1'b1;
        local_cmd.push = 1'b1;
        pair_cmd.push  = 1'b1;
        set_emit       = 1'b1;
        set_ovf        = main_full || local_full || pair_full;
      end
      S_OFF1: begin
        priority if (remap_fill == '0) begin
          main_cmd.remove  = 1'b1;
          local_cmd.remove = 1'b1;
          set_emit         = 1'b1;
        end else if (pair_hit) begin
          set_emit   = 1'b1;
          emit_pitch = pair_first[PITCH_W-1:0];
        end else if (local_hit) begin
          main_cmd.remove  = 1'b1;
          local_cmd.remove = 1'b1;
          set_emit         = 1'b1;
        end else begin
          set_emit = 1'b0;
        end
      end
      S_PAIRS: begin
        if (pair_hit) begin
          pair_cmd.remove = 1'b1;
        end else begin
          key_load = 1'b1;
          key_val  = opitch;
        end
      end
      S_REMOVE: begin
        main_cmd.remove  = 1'b1;
        local_cmd.remove = 1'b1;
      end
      S_EXT: begin
        if (vel != '0) begin
          main_cmd.push = 1'b1;
          set_ovf       = main_full;
        end else begin
          main_cmd.remove = 1'b1;
        end
      end
      S_CLR: begin
        main_cmd.clear  = 1'b1;
        local_cmd.clear = 1'b1;
        pair_cmd.clear  = 1'b1;
      end
      S_IDLE, S_DONE: begin
        set_emit = 1'b0;
      end
      default: begin
        set_emit = 1'b0;
      end
    endcase
  end

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the transaction and track the result
  always_ff @(posedge clk) begin
    if (accept) begin
      req    <= req_type;
      pitch  <= note_pitch;
      vel    <= note_velocity;
      key    <= note_pitch;
      emit   <= 1'b0;
      ovf    <= 1'b0;
      opitch <= note_pitch;
    end else begin
      if (key_load) key <= key_val;
      if (set_emit) begin
        emit   <= 1'b1;
        opitch <= emit_pitch;
      end
      if (set_ovf) ovf <= 1'b1;
    end
  end

  // Track fill counts alongside the rows
  always_ff @(posedge clk) begin
    if (rst) begin
      main_fill  <= '0;
      local_fill <= '0;
      remap_fill <= '0;
    end else begin
      if (main_cmd.clear) main_fill <= '0;
      else if (main_cmd.push && !main_full) main_fill <= main_fill + MFW'(1);
      else if (main_cmd.remove && main_hit) main_fill <= main_fill - MFW'(1);

      if (local_cmd.clear) local_fill <= '0;
      else if (local_cmd.push && !local_full) local_fill <= local_fill + LFW'(1);
      else if (local_cmd.remove && local_hit) local_fill <= local_fill - LFW'(1);

      if (pair_cmd.clear) remap_fill <= '0;
      else if (pair_cmd.push && !pair_full) remap_fill <= remap_fill + RFW'(1);
      else if (pair_cmd.remove && pair_hit) remap_fill <= remap_fill - RFW'(1);
    end
  end

  assign mf32 = 32'(main_fill);
  assign lf32 = 32'(local_fill);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      note_valid     <= emit;
      out_pitch      <= emit ? opitch : '0;
      out_velocity   <= emit ? vel : '0;
      was_reassigned <= emit && (opitch != pitch);
      store_overflow <= ovf;
      main_count     <= mf32[8:0];
      local_count    <= lf32[5:0];
    end
  end

  // Checks
  a_reassign_emits: assert property (@(posedge clk) disable iff (rst)
    out_valid && was_reassigned |-> note_valid)
    else $error("reassigned flag without a note");

  a_main_bound: assert property (@(posedge clk) disable iff (rst)
    32'(main_fill) <= MAIN_DEPTH)
    else $error("main fill beyond depth");

  a_local_bound: assert property (@(posedge clk) disable iff (rst)
    32'(local_fill) <= LOCAL_DEPTH)
    else $error("local fill beyond depth");

  a_pair_remove_exit: assert property (@(posedge clk) disable iff (rst)
    state == S_PAIRS && !pair_hit |=> state == S_REMOVE)
    else $error("pair sweep did not hand over to removal");

endmodule

>>> tb/sv/mcnf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcnf_checker
// Watches both channels of the cluster note filter. It keeps its own copy of
// the held-note, local-note and pitch-pair lists, works out the expected
// result for every accepted request and compares each result field by field.
// ----------------------------------------------------------------------------
module mcnf_checker
  import mcnf_pkg::*;
#(
  parameter int MAIN_DEPTH  = 256,
  parameter int LOCAL_DEPTH = 32,
  parameter int REMAP_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [6:0]  note_pitch,
  input  logic [6:0]  note_velocity,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        note_valid,
  input  logic [6:0]  out_pitch,
  input  logic [6:0]  out_velocity,
  input  logic        was_reassigned,
  input  logic        store_overflow,
  input  logic [8:0]  main_count,
  input  logic [5:0]  local_count,
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    logic       note_valid;
    logic [6:0] pitch;
    logic [6:0] velocity;
    logic       reassigned;
    logic       overflow;
    logic [8:0] main_count;
    logic [5:0] local_count;
  } note_result_t;

  note_result_t expected_notes[$];

  // Shadow lists; ordered, newest at the back
  logic [6:0] held_all[$];
  logic [6:0] held_local[$];
  logic [6:0] pair_orig[$];
  logic [6:0] pair_moved[$];
  logic       overflow_seen;

  function automatic bit is_near(int a, int b);
    int d;
    d = a - b;
    return d == 1 || d == 2 || d == -1 || d == -2;
  endfunction

  function automatic bit holds(ref logic [6:0] lst[$], input int v);
    foreach (lst[i]) if (lst[i] == v) return 1;
    return 0;
  endfunction

  function automatic void drop_first(ref logic [6:0] lst[$], input int v);
    foreach (lst[i]) if (lst[i] == v) begin
      lst.delete(i);
      return;
    end
  endfunction

  function automatic void add_to(ref logic [6:0] lst[$], input int depth, input int v);
    if (lst.size() >= depth) overflow_seen = 1;
    else lst = {lst, v[6:0]};
  endfunction

  // Last held note within two semitones, else the pitch itself
  function automatic int nearest_held(int p);
    int r;
    r = p;
    foreach (held_all[i]) if (is_near(p, held_all[i])) r = held_all[i];
    return r;
  endfunction

  function automatic void hold_note(int p);
    add_to(held_local, LOCAL_DEPTH, p);
    add_to(held_all, MAIN_DEPTH, p);
  endfunction

  function automatic note_result_t filter_note(logic [1:0] req, int pitch, int vel);
    note_result_t r;
    bit emit, blocked;
    int opitch, p1, p2, p3, chosen, found;
    emit = 0;
    opitch = 0;
    overflow_seen = 0;
    if (req == REQ_LOCAL) begin
      if (vel > 0) begin
        if (held_all.size() == 0) begin
          hold_note(pitch);
          emit = 1;
          opitch = pitch;
        end else if (holds(held_local, pitch)) begin
          emit = 1;
          opitch = pitch;
        end else begin
          blocked = 0;
          foreach (held_local[i]) if (is_near(pitch, held_local[i])) blocked = 1;
          if (!blocked) begin
            p1 = nearest_held(pitch);
            if (p1 == pitch) begin
              hold_note(pitch);
              emit = 1;
              opitch = pitch;
            end else begin
              chosen = -1;
              p2 = nearest_held(p1);
              if (p2 == p1) chosen = p1;
              else begin
                p3 = nearest_held(p2);
                if (p3 == p2) chosen = p2;
              end
              if (chosen >= 0) begin
                hold_note(chosen);
                if (pair_orig.size() >= REMAP_DEPTH) overflow_seen = 1;
                else begin
                  pair_orig  = {pair_orig, pitch[6:0]};
                  pair_moved = {pair_moved, chosen[6:0]};
                end
                emit = 1;
                opitch = chosen;
              end
            end
          end
        end
      end else begin
        found = -1;
        foreach (pair_orig[i]) if (found < 0 && pair_orig[i] == pitch) found = pair_moved[i];
        if (pair_orig.size() == 0) begin
          emit = 1;
          opitch = pitch;
          drop_first(held_local, pitch);
          drop_first(held_all, pitch);
        end else if (found >= 0) begin
          emit = 1;
          opitch = found;
          // remove every pair with this original
          for (int i = pair_orig.size() - 1; i >= 0; i--)
            if (pair_orig[i] == pitch) begin
              pair_orig.delete(i);
              pair_moved.delete(i);
            end
          drop_first(held_all, found);
          drop_first(held_local, found);
        end else if (holds(held_local, pitch)) begin
          emit = 1;
          opitch = pitch;
          drop_first(held_local, pitch);
          drop_first(held_all, pitch);
        end
      end
    end else if (req == REQ_EXT) begin
      if (vel > 0) add_to(held_all, MAIN_DEPTH, pitch);
      else drop_first(held_all, pitch);
    end else if (req == REQ_CLEAR) begin
      held_all.delete();
      held_local.delete();
      pair_orig.delete();
      pair_moved.delete();
    end
    r.note_valid  = emit;
    r.pitch       = emit ? opitch[6:0] : 7'd0;
    r.velocity    = emit ? vel[6:0] : 7'd0;
    r.reassigned  = emit && opitch != pitch;
    r.overflow    = overflow_seen;
    r.main_count  = 9'(held_all.size());
    r.local_count = 6'(held_local.size());
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // Predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    note_result_t want;
    if (rst) begin
      fail_count = 0;
      pending_count <= 0;
    end else begin
      if (in_valid && !in_stall)
        expected_notes = {expected_notes,
                          filter_note(req_type, int'(note_pitch), int'(note_velocity))};
      if (out_valid && !out_stall) begin
        if (expected_notes.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = expected_notes.pop_front();
          if (note_valid != want.note_valid)
            report_mismatch("note_valid", note_valid, want.note_valid);
          if (out_pitch != want.pitch) report_mismatch("out_pitch", out_pitch, want.pitch);
          if (out_velocity != want.velocity)
            report_mismatch("out_velocity", out_velocity, want.velocity);
          if (was_reassigned != want.reassigned)
            report_mismatch("was_reassigned", was_reassigned, want.reassigned);
          if (store_overflow != want.overflow)
            report_mismatch("store_overflow", store_overflow, want.overflow);
          if (main_count != want.main_count)
            report_mismatch("main_count", main_count, want.main_count);
          if (local_count != want.local_count)
            report_mismatch("local_count", local_count, want.local_count);
        end
      end
      pending_count <= expected_notes.size();
    end
  end

endmodule

>>> tb/sv/tb_midi_cluster_note_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_midi_cluster_note_filter
// Drives directed and random note traffic into the cluster note filter under
// several idle and stall mixes; the checker beside the block gives the count
// of mismatches that decides the verdict.
// ----------------------------------------------------------------------------
module tb_midi_cluster_note_filter
  import mcnf_pkg::*;
();

  localparam int IDLE_LIMIT = 4000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  req_type;
  logic [6:0]  note_pitch;
  logic [6:0]  note_velocity;
  logic        out_valid;
  logic        out_stall;
  logic        note_valid;
  logic [6:0]  out_pitch;
  logic [6:0]  out_velocity;
  logic        was_reassigned;
  logic        store_overflow;
  logic [8:0]  main_count;
  logic [5:0]  local_count;
  int          fail_count;
  int          pending_count;
  int          send_idle_pct;
  int          stall_pct;
  int          quiet_cycles;

  midi_cluster_note_filter DUT (.*);
  mcnf_checker checker_i (.*);

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Random receiver stall
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Send one transaction with a random leading gap; valid stays up until
  // the next gap or the end of the run
  task automatic send_note(logic [1:0] req, int pitch, int vel);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    req_type      <= req;
    note_pitch    <= pitch[6:0];
    note_velocity <= vel[6:0];
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Cluster of local notes around a center, then releases in random order
  task automatic play_cluster();
    int center, n, held[$], k;
    center = $urandom_range(3, 124);
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      k = center + $urandom_range(0, 6) - 3;
      held = {held, k};
      send_note(REQ_LOCAL, k, $urandom_range(1, 127));
      if ($urandom_range(9) == 0)
        send_note(REQ_EXT, center + $urandom_range(0, 4) - 2, $urandom_range(0, 127));
    end
    held.shuffle();
    foreach (held[i]) if ($urandom_range(9) != 0) send_note(REQ_LOCAL, held[i], 0);
  endtask

  task automatic random_phase(int idle, int stall, int count);
    int r;
    send_idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 60) play_cluster();
      else if (r < 75) send_note(REQ_EXT, $urandom_range(127),
                                 $urandom_range(1) ? 0 : $urandom_range(127));
      else if (r < 77) send_note(REQ_CLEAR, $urandom_range(127), $urandom_range(127));
      else if (r < 78) send_note(2'd3, $urandom_range(127), $urandom_range(127));
      else send_note(2'($urandom_range(1)), $urandom_range(127),
                     $urandom_range(1) ? 0 : $urandom_range(127));
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    req_type = REQ_LOCAL;
    note_pitch = '0;
    note_velocity = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: extremes, plays, replays, blocks, snaps, releases, clear
    send_note(REQ_LOCAL, 0, 127);
    send_note(REQ_LOCAL, 0, 1);
    send_note(REQ_LOCAL, 2, 5);
    send_note(REQ_EXT, 127, 127);
    send_note(REQ_LOCAL, 126, 9);
    send_note(REQ_LOCAL, 126, 0);
    send_note(REQ_LOCAL, 0, 0);
    send_note(REQ_LOCAL, 50, 0);
    send_note(REQ_EXT, 127, 0);
    send_note(REQ_EXT, 60, 64);
    send_note(REQ_EXT, 62, 64);
    send_note(REQ_EXT, 64, 64);
    send_note(REQ_LOCAL, 63, 100);
    send_note(REQ_LOCAL, 61, 100);
    send_note(REQ_LOCAL, 63, 0);
    send_note(REQ_LOCAL, 61, 0);
    send_note(2'd3, 127, 127);
    send_note(REQ_CLEAR, 85, 42);
    // Overflow the local list: spaced pitches
    for (int i = 0; i < 34; i++) send_note(REQ_LOCAL, i * 3 + 1, 85);
    send_note(REQ_CLEAR, 0, 0);
    // Overflow the held-note list
    for (int i = 0; i < 258; i++) send_note(REQ_EXT, $urandom_range(127), 1);
    send_note(REQ_CLEAR, 0, 0);

    random_phase(0, 0, 50);
    random_phase(54, 0, 50);
    random_phase(0, 54, 50);
    random_phase(38, 38, 50);
    random_phase(0, 0, 20);

    in_valid <= 1'b0;
    stall_pct = 0;
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
